/* hdl/modular_arithmetic_unit_core_assert.svh */
// Assertion macros for the checker of the modular arithmetic unit.
`ifndef MODULAR_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define MODULAR_ARITHMETIC_UNIT_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MAU_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MAU_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mau_pkg.sv */
// Package with widths, codes and types of the modular arithmetic unit.
package mau_pkg;

  // Operand and modulus width.
  localparam int OPW = 31;
  // Width of the command field.
  localparam int CMD_W = 3;
  // Configuration port widths.
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // Counter widths: one serial multiply runs OPW steps, one power OPW exponent bits.
  localparam int MCNT_W = $clog2(OPW);
  localparam int ECNT_W = $clog2(OPW + 1);

  // Modulus after reset.
  localparam logic [OPW-1:0] MODULUS_RESET = OPW'(1000000007);

  // Operation codes.
  localparam logic [CMD_W-1:0] CMD_ADD = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_SUB = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_MUL = CMD_W'(2);
  localparam logic [CMD_W-1:0] CMD_POW = CMD_W'(3);
  localparam logic [CMD_W-1:0] CMD_DIV = CMD_W'(4);

  // Register index of the modulus (word address on the configuration port).
  localparam logic [ADDR_W-3:0] REG_MODULUS = '0;

  // Mode of the shared modular step unit.
  typedef struct packed {
    logic dbl;
    logic neg;
  } step_op_t;

  // Sequencer status towards the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } seq_stat_t;

  // One finished result.
  typedef struct packed {
    logic [OPW-1:0] result;
    logic           zero_divisor;
  } res_t;

endpackage

/* hdl/mau_modstep.sv */
// Shared modular step unit: (2*acc or acc) plus addend or (m - addend), reduced mod m.
module mau_modstep (
  input  logic [mau_pkg::OPW-1:0] m_i,
  input  logic [mau_pkg::OPW-1:0] acc_i,
  input  logic [mau_pkg::OPW-1:0] addend_i,
  input  mau_pkg::step_op_t       op_i,
  output logic [mau_pkg::OPW-1:0] res_o
);
  import mau_pkg::*;

  logic [OPW:0]   base;
  logic [OPW:0]   term;
  logic [OPW+1:0] sum;
  logic [OPW+2:0] diff1;
  logic [OPW+2:0] diff2;

  // Both inputs are below m, so the raw sum stays below 3m.
  assign base = op_i.dbl ? {acc_i, 1'b0} : {1'b0, acc_i};
  assign term = op_i.neg ? ({1'b0, m_i} - {1'b0, addend_i}) : {1'b0, addend_i};
  assign sum  = {1'b0, base} + {1'b0, term};

  // Trial subtraction of m and of 2m; the sign bit tells which one fits.
  assign diff1 = {1'b0, sum} - {3'b000, m_i};
  assign diff2 = {1'b0, sum} - {2'b00, m_i, 1'b0};

  always_comb begin
    if (!diff2[OPW+2]) begin
      res_o = diff2[OPW-1:0];
    end else if (!diff1[OPW+2]) begin
      res_o = diff1[OPW-1:0];
    end else begin
      res_o = sum[OPW-1:0];
    end
  end

endmodule

/* hdl/mau_seq.sv */
// Sequencer that drives the shared step unit through reduction, add, subtract, multiply and power.
module mau_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [mau_pkg::OPW-1:0]   m_i,
  input  logic                      start_i,
  input  logic [mau_pkg::CMD_W-1:0] cmd_i,
  input  logic [mau_pkg::OPW-1:0]   a_i,
  input  logic [mau_pkg::OPW-1:0]   b_i,
  input  logic                      ack_i,
  output mau_pkg::seq_stat_t        stat_o,
  output mau_pkg::res_t             res_o
);
  import mau_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ALU,
    S_POW,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    PH_RED_A,
    PH_RED_B,
    PH_SQ,
    PH_ML,
    PH_FINAL
  } phase_e;

  localparam logic [MCNT_W-1:0] MCNT_LAST = MCNT_W'(OPW - 1);
  localparam logic [ECNT_W-1:0] ECNT_FULL = ECNT_W'(OPW);
  localparam logic [OPW-1:0]    ONE       = OPW'(1);

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [OPW-1:0]    res_q, res_d;
  logic              zd_q, zd_d;

  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [OPW-1:0]    a_q, a_d;
  logic [OPW-1:0]    b_q, b_d;
  logic [OPW-1:0]    br_q, br_d;
  logic [OPW-1:0]    mx_q, mx_d;
  logic [OPW-1:0]    my_q, my_d;
  logic [OPW-1:0]    acc_q, acc_d;
  logic [OPW-1:0]    x_q, x_d;
  logic [OPW-1:0]    e_q, e_d;
  logic [OPW-1:0]    r_q, r_d;
  logic [MCNT_W-1:0] mcnt_q, mcnt_d;
  logic [ECNT_W-1:0] ecnt_q, ecnt_d;

  logic [OPW-1:0]    step_acc;
  logic [OPW-1:0]    step_addend;
  step_op_t          step_op;
  logic [OPW-1:0]    step_res;

  // Operand selection for the shared unit: one add or subtract, or one
  // multiply step (acc = 2*acc + multiplier bit * multiplicand).
  always_comb begin
    if (state_q == S_ALU) begin
      step_acc    = a_q;
      step_addend = br_q;
      step_op.dbl = 1'b0;
      step_op.neg = (cmd_q == CMD_SUB);
    end else begin
      step_acc    = acc_q;
      step_addend = my_q[OPW-1] ? mx_q : '0;
      step_op.dbl = 1'b1;
      step_op.neg = 1'b0;
    end
  end

  mau_modstep u_step (
    .m_i      (m_i),
    .acc_i    (step_acc),
    .addend_i (step_addend),
    .op_i     (step_op),
    .res_o    (step_res)
  );

  // Next-state and datapath control.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    res_d   = res_q;
    zd_d    = zd_q;
    cmd_d   = cmd_q;
    a_d     = a_q;
    b_d     = b_q;
    br_d    = br_q;
    mx_d    = mx_q;
    my_d    = my_q;
    acc_d   = acc_q;
    x_d     = x_q;
    e_d     = e_q;
    r_d     = r_q;
    mcnt_d  = mcnt_q;
    ecnt_d  = ecnt_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d = cmd_i;
          b_d   = b_i;
          if ((m_i < OPW'(2)) || (cmd_i > CMD_DIV)) begin
            // Degenerate modulus or unused code: answer at once.
            res_d   = '0;
            zd_d    = (cmd_i == CMD_DIV);
            state_d = S_DONE;
          end else begin
            // Reduce operand a as the product 1 * a.
            mx_d    = ONE;
            my_d    = a_i;
            acc_d   = '0;
            mcnt_d  = MCNT_LAST;
            phase_d = PH_RED_A;
            state_d = S_MUL;
          end
        end
      end

      S_MUL: begin
        acc_d  = step_res;
        my_d   = {my_q[OPW-2:0], 1'b0};
        mcnt_d = mcnt_q - MCNT_W'(1);
        if (mcnt_q == '0) begin
          case (phase_q)
            PH_RED_A: begin
              a_d     = step_res;
              mx_d    = ONE;
              my_d    = b_q;
              acc_d   = '0;
              mcnt_d  = MCNT_LAST;
              phase_d = PH_RED_B;
            end
            PH_RED_B: begin
              br_d = step_res;
              case (cmd_q)
                CMD_ADD, CMD_SUB: begin
                  state_d = S_ALU;
                end
                CMD_MUL: begin
                  mx_d    = a_q;
                  my_d    = step_res;
                  acc_d   = '0;
                  mcnt_d  = MCNT_LAST;
                  phase_d = PH_FINAL;
                end
                CMD_POW: begin
                  x_d     = a_q;
                  e_d     = b_q;
                  r_d     = ONE;
                  ecnt_d  = ECNT_FULL;
                  state_d = S_POW;
                end
                CMD_DIV: begin
                  if (step_res == '0) begin
                    res_d   = '0;
                    zd_d    = 1'b1;
                    state_d = S_DONE;
                  end else begin
                    // Inverse of b as b^(m-2).
                    x_d     = step_res;
                    e_d     = m_i - OPW'(2);
                    r_d     = ONE;
                    ecnt_d  = ECNT_FULL;
                    state_d = S_POW;
                  end
                end
                default: begin
                  res_d   = '0;
                  zd_d    = 1'b0;
                  state_d = S_DONE;
                end
              endcase
            end
            PH_SQ: begin
              r_d = step_res;
              if (e_q[OPW-1]) begin
                mx_d    = step_res;
                my_d    = x_q;
                acc_d   = '0;
                mcnt_d  = MCNT_LAST;
                phase_d = PH_ML;
              end else begin
                e_d     = {e_q[OPW-2:0], 1'b0};
                ecnt_d  = ecnt_q - ECNT_W'(1);
                state_d = S_POW;
              end
            end
            PH_ML: begin
              r_d     = step_res;
              e_d     = {e_q[OPW-2:0], 1'b0};
              ecnt_d  = ecnt_q - ECNT_W'(1);
              state_d = S_POW;
            end
            PH_FINAL: begin
              res_d   = step_res;
              zd_d    = 1'b0;
              state_d = S_DONE;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_ALU: begin
        res_d   = step_res;
        zd_d    = 1'b0;
        state_d = S_DONE;
      end

      // One exponent bit, most significant first: square, then multiply if set.
      S_POW: begin
        if (ecnt_q == '0) begin
          if (cmd_q == CMD_POW) begin
            res_d   = r_q;
            zd_d    = 1'b0;
            state_d = S_DONE;
          end else begin
            mx_d    = a_q;
            my_d    = r_q;
            acc_d   = '0;
            mcnt_d  = MCNT_LAST;
            phase_d = PH_FINAL;
            state_d = S_MUL;
          end
        end else begin
          mx_d    = r_q;
          my_d    = r_q;
          acc_d   = '0;
          mcnt_d  = MCNT_LAST;
          phase_d = PH_SQ;
          state_d = S_MUL;
        end
      end

      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_RED_A;
      res_q   <= '0;
      zd_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      res_q   <= res_d;
      zd_q    <= zd_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    a_q    <= a_d;
    b_q    <= b_d;
    br_q   <= br_d;
    mx_q   <= mx_d;
    my_q   <= my_d;
    acc_q  <= acc_d;
    x_q    <= x_d;
    e_q    <= e_d;
    r_q    <= r_d;
    mcnt_q <= mcnt_d;
    ecnt_q <= ecnt_d;
  end

  assign stat_o.busy         = (state_q != S_IDLE);
  assign stat_o.done         = (state_q == S_DONE);
  assign res_o.result        = res_q;
  assign res_o.zero_divisor  = zd_q;

endmodule

/* hdl/modular_arithmetic_unit_core.sv */
// A single step unit serves every operation, one request at a time. A modulus below 2
// or an unused code is answered at once; otherwise both operands are reduced, then add
// or subtract takes one step, multiply one serial multiply, power a square per exponent
// bit plus one per set bit, divide a*b^(m-2); a reduction or multiply has 31 steps.
// Reset is asynchronous and active low; it restores the modulus to 1000000007.
// The result register lets the next request start while a result waits to be taken.
module modular_arithmetic_unit_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mau_pkg::ADDR_W-1:0] paddr,
  input  logic [mau_pkg::DATA_W-1:0] pwdata,
  output logic [mau_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [mau_pkg::CMD_W-1:0]  cmd_i,
  input  logic [mau_pkg::OPW-1:0]    operand_a_i,
  input  logic [mau_pkg::OPW-1:0]    operand_b_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [mau_pkg::OPW-1:0]    result_o,
  output logic                       zero_divisor_o
);
  import mau_pkg::*;

  logic [OPW-1:0] modulus_q;
  logic           reg_sel;
  logic           start;
  logic           ack;
  seq_stat_t      stat;
  res_t           seq_res;
  logic           out_valid_q;
  res_t           out_q;

  // Configuration register.
  assign reg_sel = (paddr[ADDR_W-1:2] == REG_MODULUS);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      modulus_q <= pwdata[OPW-1:0];
    end
  end

  assign prdata = reg_sel ? {{(DATA_W - OPW){1'b0}}, modulus_q} : '0;

  // Request handshake: a new request starts only when the sequencer is idle.
  assign in_ready_o = !stat.busy;
  assign start      = in_valid_i && in_ready_o;

  mau_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .m_i     (modulus_q),
    .start_i (start),
    .cmd_i   (cmd_i),
    .a_i     (operand_a_i),
    .b_i     (operand_b_i),
    .ack_i   (ack),
    .stat_o  (stat),
    .res_o   (seq_res)
  );

  // Result register: loads when empty or emptied in the same cycle.
  assign ack = stat.done && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ack) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack) begin
      out_q <= seq_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_o       = out_q.result;
  assign zero_divisor_o = out_q.zero_divisor;

endmodule

/* hdl/mau_checker.sv */
// Port-level checker of the modular arithmetic unit, bound to the top level.
`include "modular_arithmetic_unit_core_assert.svh"

module mau_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [mau_pkg::OPW-1:0] result_o,
  input logic                    zero_divisor_o
);
  import mau_pkg::*;

  // The unit works on one request at a time, so it is busy right after taking one.
  `MAU_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "ready after request")

  // A zero divisor always comes with a zero result.
  `MAU_ASSERT_IMP(a_zero_div_result, clk_i, rst_ni, out_valid_o && zero_divisor_o, result_o == '0, "zero divisor with non-zero result")

  // A fresh result is posted in the same cycle as the unit turns idle.
  `MAU_ASSERT_IMP(a_result_ends_work, clk_i, rst_ni, $rose(out_valid_o), $rose(in_ready_o), "result without end of work")

  // A stalled result holds.
  `MAU_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(result_o) && $stable(zero_divisor_o), "stalled result changed")

endmodule

bind modular_arithmetic_unit_core mau_checker u_mau_checker (.*);

/* bench/modular_arithmetic_unit_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the modular arithmetic unit core.
module modular_arithmetic_unit_core_tb;
  import mau_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 4;
  localparam int MAX_GAP      = 4;
  localparam int MAX_REPORTS  = 10;
  // Allows every request to take as long as the slowest kind, three times over.
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int SETTLE_CYCLES = 2100;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_BURST   = 10;
  localparam int N_DIRECTED   = 25;
  localparam int N_PHASES     = 9;

  localparam logic [OPW-1:0]   OP_MAX    = '1;
  localparam logic [OPW-1:0]   M_RST_M1  = MODULUS_RESET - 31'd1;
  localparam logic [CMD_W-1:0] CMD_RSVD5 = CMD_W'(5);
  localparam logic [CMD_W-1:0] CMD_RSVD6 = CMD_W'(6);
  localparam logic [CMD_W-1:0] CMD_RSVD7 = CMD_W'(7);

  // One row of the directed table; known rows carry a hand-worked answer.
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic [OPW-1:0]   a;
    logic [OPW-1:0]   b;
    logic             known;
    logic [OPW-1:0]   res;
    logic             zdiv;
  } vector_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [CMD_W-1:0]    cmd_i;
  logic [OPW-1:0]      operand_a_i;
  logic [OPW-1:0]      operand_b_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [OPW-1:0]      result_o;
  logic                zero_divisor_o;

  // Modulus as the block should currently hold it.
  logic [OPW-1:0] modulus_now = MODULUS_RESET;
  res_t           expected_q[$];
  vector_t        directed_tbl [N_DIRECTED];
  logic [OPW-1:0] phase_mod [N_PHASES];
  int             phase_len [N_PHASES];

  int  mismatches      = 0;
  int  results_checked = 0;
  int  div_zero_seen   = 0;
  int  sent            = 0;
  int  cycles          = 0;
  int  rx_hold_cycles  = 0;
  bit  tx_no_gaps      = 1'b0;
  bit  rx_no_gaps      = 1'b0;

  modular_arithmetic_unit_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .operand_a_i    (operand_a_i),
    .operand_b_i    (operand_b_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_o       (result_o),
    .zero_divisor_o (zero_divisor_o)
  );

  // Clock with a 12 ns period.
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Full-width product; both factors are below 2^31, so 64 bits never overflow.
  function automatic logic [63:0] mul_mod(input logic [63:0] x, input logic [63:0] y,
                                          input logic [63:0] m);
    return (x * y) % m;
  endfunction

  // Square-and-multiply over every exponent bit; a zero exponent leaves 1.
  function automatic logic [63:0] pow_mod(input logic [63:0] base, input logic [OPW-1:0] expo,
                                          input logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1 % m;
    for (int i = 0; i < OPW; i++) begin
      if (expo[i]) acc = mul_mod(acc, base, m);
      base = mul_mod(base, base, m);
    end
    return acc;
  endfunction

  // Result of one request under a given modulus.
  function automatic res_t predict_result(input logic [CMD_W-1:0] op, input logic [OPW-1:0] a_raw,
                                          input logic [OPW-1:0] b_raw, input logic [OPW-1:0] m_raw);
    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] r;
    res_t        res;
    m = 64'(m_raw);
    res.result = '0;
    res.zero_divisor = 1'b0;
    // A modulus below 2 makes every result zero and every divisor congruent to zero.
    if (m < 64'd2) begin
      res.zero_divisor = (op == CMD_DIV);
      return res;
    end
    a = 64'(a_raw) % m;
    b = 64'(b_raw) % m;
    r = '0;
    case (op)
      CMD_ADD: r = (a + b) % m;
      CMD_SUB: r = (a + m - b) % m;
      CMD_MUL: r = mul_mod(a, b, m);
      CMD_POW: r = pow_mod(a, b_raw, m);
      CMD_DIV: begin
        if (b == 64'd0) res.zero_divisor = 1'b1;
        else r = mul_mod(a, pow_mod(b, OPW'(m - 64'd2), m), m);
      end
      default: r = '0;
    endcase
    res.result = r[OPW-1:0];
    return res;
  endfunction

  // Operands lean towards zero, the maximum and values next to the modulus.
  function automatic logic [OPW-1:0] pick_operand(input logic [OPW-1:0] m);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return OP_MAX;
      2: return m - 31'd1;
      3: return m;
      4: return OPW'($urandom_range(0, 16));
      default: return OPW'($urandom());
    endcase
  endfunction

  // Quick operations dominate so that the run stays short; a few unused codes are mixed in.
  function automatic logic [CMD_W-1:0] pick_cmd();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return CMD_ADD;
    else if (roll < 40) return CMD_SUB;
    else if (roll < 64) return CMD_MUL;
    else if (roll < 79) return CMD_POW;
    else if (roll < 94) return CMD_DIV;
    else if (roll < 96) return CMD_RSVD5;
    else if (roll < 98) return CMD_RSVD6;
    else return CMD_RSVD7;
  endfunction

  task automatic log_failure(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("MISMATCH at cycle %0d: %s", cycles, msg);
  endtask

  // Offers one request after a random gap (none while tx_no_gaps is set) and records its expected result once accepted.
  task automatic offer_request(input logic [CMD_W-1:0] op, input logic [OPW-1:0] a,
                               input logic [OPW-1:0] b, input res_t want);
    int gap;
    gap = tx_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(want);
    sent++;
    if ($urandom_range(0, 15) == 0) tx_no_gaps = !tx_no_gaps;
  endtask

  // Withdraws the request line and waits until every expected result has been taken.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
  endtask

  // Register write: setup cycle then access cycle; bit 31 of the data is ignored by the block.
  task automatic write_modulus(input logic [OPW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({REG_MODULUS, 2'b00});
    pwdata  <= {1'($urandom_range(0, 1)), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    modulus_now = value;
  endtask

  // Result receiver: random stalls, stretches without stalls and one long hold-off on request.
  initial begin : result_taker
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = rx_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if ($urandom_range(0, 15) == 0) rx_no_gaps = !rx_no_gaps;
    end
  end

  // Compares every accepted result with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        log_failure($sformatf("result %0d flag %0b with nothing outstanding",
                              result_o, zero_divisor_o));
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        if (zero_divisor_o === 1'b1) div_zero_seen++;
        if (result_o !== want.result || zero_divisor_o !== want.zero_divisor) begin
          log_failure($sformatf("result %0d flag %0b, expected %0d flag %0b (modulus %0d)",
                                result_o, zero_divisor_o, want.result, want.zero_divisor,
                                modulus_now));
        end
      end
    end
  end

  // Guards against a hung handshake.
  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding",
               cycles, expected_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    vector_t        row;
    res_t           want;
    logic [CMD_W-1:0] op;
    logic [OPW-1:0] a;
    logic [OPW-1:0] b;

    // Directed requests under the reset modulus: edges, every operation, zero divisors.
    directed_tbl = '{
      '{CMD_ADD,   31'd0,         31'd0,          1'b1, 31'd0,    1'b0},
      '{CMD_ADD,   OP_MAX,        OP_MAX,         1'b0, 31'd0,    1'b0},
      '{CMD_ADD,   M_RST_M1,      31'd1,          1'b1, 31'd0,    1'b0},
      '{CMD_SUB,   31'd0,         31'd1,          1'b1, M_RST_M1, 1'b0},
      '{CMD_SUB,   31'd5,         31'd5,          1'b1, 31'd0,    1'b0},
      '{CMD_SUB,   31'd0,         OP_MAX,         1'b0, 31'd0,    1'b0},
      '{CMD_MUL,   31'd0,         OP_MAX,         1'b1, 31'd0,    1'b0},
      '{CMD_MUL,   OP_MAX,        OP_MAX,         1'b0, 31'd0,    1'b0},
      '{CMD_MUL,   31'h2AAAAAAA,  31'h55555555,   1'b0, 31'd0,    1'b0},
      '{CMD_MUL,   M_RST_M1,      M_RST_M1,       1'b1, 31'd1,    1'b0},
      '{CMD_POW,   31'd5,         31'd0,          1'b1, 31'd1,    1'b0},
      '{CMD_POW,   31'd0,         31'd0,          1'b1, 31'd1,    1'b0},
      '{CMD_POW,   31'd2,         31'd10,         1'b1, 31'd1024, 1'b0},
      '{CMD_POW,   OP_MAX,        OP_MAX,         1'b0, 31'd0,    1'b0},
      '{CMD_POW,   31'd3,         31'h40000000,   1'b0, 31'd0,    1'b0},
      '{CMD_POW,   M_RST_M1,      31'd3,          1'b1, M_RST_M1, 1'b0},
      '{CMD_DIV,   31'd7,         31'd0,          1'b1, 31'd0,    1'b1},
      '{CMD_DIV,   31'd7,         MODULUS_RESET,  1'b1, 31'd0,    1'b1},
      '{CMD_DIV,   31'd6,         31'd3,          1'b1, 31'd2,    1'b0},
      '{CMD_DIV,   OP_MAX,        OP_MAX,         1'b0, 31'd0,    1'b0},
      '{CMD_DIV,   31'd1,         31'd2,          1'b0, 31'd0,    1'b0},
      '{CMD_DIV,   31'd0,         OP_MAX,         1'b1, 31'd0,    1'b0},
      '{CMD_RSVD5, OP_MAX,        OP_MAX,         1'b1, 31'd0,    1'b0},
      '{CMD_RSVD6, 31'd0,         31'd0,          1'b1, 31'd0,    1'b0},
      '{CMD_RSVD7, OP_MAX,        31'd1,          1'b1, 31'd0,    1'b0}
    };

    // Modulus settings: largest prime, smallest legal value, small primes, a composite,
    // a random value, the degenerate values 1 and 0, and finally the reset value again.
    phase_mod = '{OP_MAX, 31'd2, 31'd97, 31'd65537, 31'd1000, OPW'($urandom()),
                  31'd1, 31'd0, MODULUS_RESET};
    phase_len = '{50, 35, 35, 35, 30, 35, 10, 10, 30};

    // Quiet inputs and reset.
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    cmd_i       = CMD_ADD;
    operand_a_i = '0;
    operand_b_i = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_tbl[i]) begin
      row = directed_tbl[i];
      if (row.known) begin
        want.result       = row.res;
        want.zero_divisor = row.zdiv;
      end else begin
        want = predict_result(row.op, row.a, row.b, modulus_now);
      end
      offer_request(row.op, row.a, row.b, want);
    end

    // Back-pressure: the receiver holds off while short requests keep coming.
    wait_drained();
    rx_hold_cycles = HOLD_CYCLES;
    repeat (HOLD_BURST) begin
      op = ($urandom_range(0, 1) == 0) ? CMD_ADD : CMD_SUB;
      a  = pick_operand(modulus_now);
      b  = pick_operand(modulus_now);
      offer_request(op, a, b, predict_result(op, a, b, modulus_now));
    end

    // Random requests, one batch per modulus setting, written while the block is idle.
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      write_modulus(phase_mod[p]);
      repeat (phase_len[p]) begin
        op = pick_cmd();
        a  = pick_operand(modulus_now);
        b  = pick_operand(modulus_now);
        offer_request(op, a, b, predict_result(op, a, b, modulus_now));
      end
    end

    // Let the last results out, then watch for stray ones.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0) log_failure("results still outstanding at the end");

    $display("Sent %0d requests (%0d directed) under %0d modulus settings; %0d results checked.",
             sent, N_DIRECTED, N_PHASES + 1, results_checked);
    $display("%0d divides reported a zero divisor; %0d mismatches in %0d cycles.",
             div_zero_seen, mismatches, cycles);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
